/* design/lcg_permuted_random_bounded_unit_defines.svh */
// Assertion macros shared by the checker file.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef LCG_PERMUTED_RANDOM_BOUNDED_UNIT_DEFINES_SVH
`define LCG_PERMUTED_RANDOM_BOUNDED_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked after the antecedent, with a delay set by argument n.
`define LPRB_ASSERT_LATER(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##n (cons)) \
    else $error(msg);

`endif

/* design/lprb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lprb_pkg;

  localparam int unsigned STATE_W     = 64;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MUL_CHUNK_W = 16;
  localparam int unsigned MUL_STEPS   = STATE_W / MUL_CHUNK_W;
  localparam int unsigned MUL_IDX_W   = $clog2(MUL_STEPS);
  localparam int unsigned DIV_BITS    = 2;   // quotient bits retired per cycle
  localparam int unsigned DIV_CYCLES  = WORD_W / DIV_BITS;
  localparam int unsigned CNT_W       = $clog2(DIV_CYCLES);
  localparam int unsigned XSH         = 22;  // xorshift amount
  localparam int unsigned SHIFT_BASE  = 22;  // base of the variable shift

  localparam logic [STATE_W-1:0]   LCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(DIV_CYCLES - 1);
  localparam logic [MUL_IDX_W-1:0] MUL_LAST = MUL_IDX_W'(MUL_STEPS - 1);

  typedef enum logic [1:0] {
    ACT_RAW     = 2'd0,
    ACT_BOUNDED = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [0:0] {
    CFG_START_STATE = 1'b0,
    CFG_STREAM_INCR = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RES_WORD,
    RES_REM,
    RES_ZERO
  } res_sel_t;

  typedef enum logic {
    DIV_THRESH,
    DIV_WORD
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BCHK,
    ST_THR,
    ST_TSAVE,
    ST_MUL,
    ST_PERM,
    ST_CHK,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 load_bound;
    logic                 restart;
    logic                 mul_init;
    logic                 mul_step;
    logic [MUL_IDX_W-1:0] mul_idx;
    logic                 state_commit;
    logic                 div_init;
    div_sel_t             div_sel;
    logic                 div_step;
    logic                 thr_save;
    logic                 res_load;
    res_sel_t             res_sel;
  } lprb_cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic below_thr;
  } lprb_sts_t;

endpackage

`default_nettype wire

/* design/lprb_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Request channel: action and bound.
interface lprb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] bound;

  modport source (output valid, output action, output bound, input ready);
  modport sink   (input valid, input action, input bound, output ready);
endinterface

// Result channel: one 32-bit value.
interface lprb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* design/lprb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lprb_ctrl import lprb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output lprb_cmd_t  cmd,
  input  lprb_sts_t  sts
);

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            bounded_r, bounded_nxt;
  res_sel_t        res_sel_r, res_sel_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      bounded_r   <= 1'b0;
      res_sel_r   <= RES_WORD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bounded_r   <= bounded_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bounded_nxt   = bounded_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_idx   = cnt_r[MUL_IDX_W-1:0];
    cmd.res_sel   = res_sel_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (action_t'(in_action))
            ACT_RAW: begin
              cmd.mul_init = 1'b1;
              bounded_nxt  = 1'b0;
              cnt_nxt      = '0;
              state_nxt    = ST_MUL;
            end
            ACT_BOUNDED: begin
              cmd.load_bound = 1'b1;
              bounded_nxt    = 1'b1;
              state_nxt      = ST_BCHK;
            end
            ACT_RESTART: begin
              cmd.restart = 1'b1;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end

      ST_BCHK: begin
        if (sts.bound_zero) begin
          res_sel_nxt = RES_ZERO;
          state_nxt   = ST_DONE;
        end else begin
          cmd.div_init = 1'b1;
          cmd.div_sel  = DIV_THRESH;
          cnt_nxt      = '0;
          state_nxt    = ST_THR;
        end
      end

      ST_THR: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_TSAVE;
        end
      end

      ST_TSAVE: begin
        cmd.thr_save = 1'b1;
        cmd.mul_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end

      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r[MUL_IDX_W-1:0] == MUL_LAST) begin
          state_nxt = ST_PERM;
        end
      end

      ST_PERM: begin
        cmd.state_commit = 1'b1;
        state_nxt        = ST_CHK;
      end

      ST_CHK: begin
        if (!bounded_r) begin
          res_sel_nxt = RES_WORD;
          state_nxt   = ST_DONE;
        end else if (sts.below_thr) begin
          // biased draw: go around again
          cmd.mul_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MUL;
        end else begin
          cmd.div_init = 1'b1;
          cmd.div_sel  = DIV_WORD;
          cnt_nxt      = '0;
          state_nxt    = ST_MOD;
        end
      end

      ST_MOD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          res_sel_nxt = RES_REM;
          state_nxt   = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/lprb_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lprb_datapath import lprb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [STATE_W-1:0] cfg_wdata,
  input  logic [WORD_W-1:0]  in_bound,
  input  lprb_cmd_t          cmd,
  output lprb_sts_t          sts,
  output logic [WORD_W-1:0]  out_value
);

  logic [STATE_W-1:0] start_r;
  logic [STATE_W-1:0] incr_r;
  logic [STATE_W-1:0] gen_state_r;
  logic [STATE_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [WORD_W-1:0]  bound_r;
  logic [WORD_W-1:0]  thr_r;
  logic [WORD_W-1:0]  rem_r, rem_nxt;
  logic [WORD_W-1:0]  dvd_r, dvd_nxt;
  logic [WORD_W-1:0]  value_r;

  logic [MUL_CHUNK_W-1:0]         chunk;
  logic [STATE_W+MUL_CHUNK_W-1:0] prod;
  logic [STATE_W-1:0]             partial;

  // xorshift, variable shift by the top three bits, fold in upper half
  function automatic logic [WORD_W-1:0] permute(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] mixed;
    logic [STATE_W-1:0] shifted;
    logic [5:0]         sh;
    mixed   = s ^ (s >> XSH);
    sh      = 6'(SHIFT_BASE) + {3'b000, s[STATE_W-1 -: 3]};
    shifted = mixed >> sh;
    return shifted[WORD_W-1:0] ^ s[STATE_W-1 -: WORD_W];
  endfunction

  // one 64x16 partial product per step, truncated mod 2^64
  always_comb begin
    chunk   = LCG_MULT[cmd.mul_idx*MUL_CHUNK_W +: MUL_CHUNK_W];
    prod    = (STATE_W+MUL_CHUNK_W)'(gen_state_r) * (STATE_W+MUL_CHUNK_W)'(chunk);
    partial = prod[STATE_W-1:0] << (cmd.mul_idx * MUL_CHUNK_W);
    acc_nxt = acc_r + partial;
  end

  assign word_nxt = permute(acc_r);

  // restoring remainder, DIV_BITS steps per cycle
  always_comb begin
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] d;
    logic [WORD_W:0]   t;
    r = rem_r;
    d = dvd_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, d[WORD_W-1]};
      d = d << 1;
      if (t >= {1'b0, bound_r}) begin
        r = WORD_W'(t - {1'b0, bound_r});
      end else begin
        r = t[WORD_W-1:0];
      end
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      incr_r      <= STATE_W'(1);
      gen_state_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_START_STATE: start_r <= cfg_wdata;
          CFG_STREAM_INCR: incr_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.restart) begin
        gen_state_r <= start_r;
      end else if (cmd.state_commit) begin
        gen_state_r <= acc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bound) begin
      bound_r <= in_bound;
    end
    if (cmd.mul_init) begin
      acc_r <= incr_r | STATE_W'(1);  // increment forced odd
    end else if (cmd.mul_step) begin
      acc_r <= acc_nxt;
    end
    if (cmd.state_commit) begin
      word_r <= word_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= (cmd.div_sel == DIV_THRESH) ? ((~bound_r) + WORD_W'(1)) : word_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
    if (cmd.thr_save) begin
      thr_r <= rem_r;
    end
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_WORD: value_r <= word_r;
        RES_REM:  value_r <= rem_r;
        RES_ZERO: value_r <= '0;
        default:  value_r <= '0;
      endcase
    end
  end

  assign sts.bound_zero = (bound_r == '0);
  assign sts.below_thr  = (word_r < thr_r);
  assign out_value      = value_r;

endmodule

`default_nettype wire

/* design/lcg_permuted_random_bounded_unit.sv */
// A restart reloads the generator state and produces no result.
// Throughput: one request at a time, taken again once the result is loaded;
//   a radix-4 remainder unit and a 4-step 64x16 multiplier set it.
//   A held result stalls a finished draw in its last state until taken.
// Reset: synchronous, active low; state 0, start_state 0, stream_increment 1.
`timescale 1ns / 1ps
`default_nettype none

module lcg_permuted_random_bounded_unit import lprb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lprb_in_if.sink            in_ch,
  lprb_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_idx,
  input  logic [STATE_W-1:0] cfg_wdata
);

  // controller <-> datapath
  lprb_cmd_t cmd;
  lprb_sts_t sts;

  logic out_valid;
  logic in_ready;
  logic [WORD_W-1:0] out_value;

  // Controller: sequences restart, threshold remainder, the multiply steps
  // of each draw, the rejection loop and the final remainder. It also owns
  // the result valid flag; a held result stalls a finished draw until taken.
  lprb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: config registers, generator state, multiply accumulator,
  // output permutation, shared remainder unit and the result register.
  lprb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_bound  (in_ch.bound),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_value)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.value = out_value;

endmodule

`default_nettype wire

/* design/lprb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "lcg_permuted_random_bounded_unit_defines.svh"

module lprb_props import lprb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic [31:0] in_bound,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `LPRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "result dropped or changed while stalled")
  `LPRB_ASSERT_NEXT(a_busy_after_draw, in_acc && (in_action == ACT_RAW || in_action == ACT_BOUNDED), !in_ready, "request taken while a draw is in flight")
  `LPRB_ASSERT_NEXT(a_restart_silent, in_acc && in_action == ACT_RESTART && !out_valid, !out_valid, "restart produced a result")
  `LPRB_ASSERT_LATER(a_zero_bound, in_acc && in_action == ACT_BOUNDED && in_bound == 32'd0 && !out_valid, 2, out_valid && out_value == 32'd0, "bound zero did not give zero")

endmodule

bind lcg_permuted_random_bounded_unit lprb_props u_lprb_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .in_bound  (in_ch.bound),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

`default_nettype wire
